[hw/rtl/pfd_pkg.sv]
`default_nettype none

package pfd_pkg;

  localparam int unsigned RATE_W   = 24;
  localparam int unsigned FREQ_W   = 24;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEC_W    = 14;

  localparam logic [RATE_W-1:0] RATE_RESET  = 24'd1000000;
  localparam logic [FREQ_W-1:0] DIGIT_LIMIT = 24'd9999;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

  typedef enum logic [STATUS_W-1:0] {
    PFD_OK   = 2'd0,
    PFD_SAT  = 2'd1,
    PFD_ZERO = 2'd2
  } pfd_status_e;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              zero;
  } pfd_div_res_t;

endpackage

`default_nettype wire

[hw/rtl/pfd_if.sv]
`default_nettype none

interface pfd_in_if #(
  parameter int unsigned COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] count;

  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

interface pfd_out_if import pfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FREQ_W-1:0]   frequency;
  logic [DIGIT_W-1:0]  digit_thousands;
  logic [DIGIT_W-1:0]  digit_hundreds;
  logic [DIGIT_W-1:0]  digit_tens;
  logic [DIGIT_W-1:0]  digit_ones;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, output frequency, output digit_thousands, output digit_hundreds,
    output digit_tens, output digit_ones, output status, input ready
  );
  modport sink (
    input valid, input frequency, input digit_thousands, input digit_hundreds,
    input digit_tens, input digit_ones, input status, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/pfd_div.sv]
`default_nettype none

module pfd_div import pfd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [RATE_W-1:0] rate_i,
  pfd_in_if.sink                 in_if,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output pfd_div_res_t           res_o
);

  localparam int unsigned STAGES = FREQ_W + 1;
  localparam int unsigned REM_W  = COUNT_BITS + 2;
  localparam int unsigned SUM_W  = ((RATE_W > COUNT_BITS) ? RATE_W : COUNT_BITS) + 1;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] en;
  logic [REM_W-1:0]  rem_q  [STAGES];
  logic [FREQ_W-1:0] num_q  [STAGES];
  logic [FREQ_W-1:0] quo_q  [STAGES];
  logic [COUNT_BITS:0] den_q [STAGES];
  logic              zero_q [STAGES];
  logic [SUM_W-1:0]  sum;

  // numerator rate + count, divisor 2 * count
  assign sum = SUM_W'(rate_i) + SUM_W'(in_if.count);

  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en[k] = res_ready_i | ~(&valid_q[STAGES-1:k]);
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en[0]) begin
      valid_q[0] <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_if.valid) begin
      rem_q[0]  <= REM_W'(sum >> FREQ_W);
      num_q[0]  <= sum[FREQ_W-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= {in_if.count, 1'b0};
      zero_q[0] <= (in_if.count == '0);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = {rem_q[k-1][REM_W-2:0], num_q[k-1][FREQ_W-1]};
      take  = (trial >= REM_W'(den_q[k-1]));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en[k]) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && valid_q[k-1]) begin
        rem_q[k]  <= take ? (trial - REM_W'(den_q[k-1])) : trial;
        num_q[k]  <= {num_q[k-1][FREQ_W-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][FREQ_W-2:0], take};
        den_q[k]  <= den_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign res_valid_o = valid_q[STAGES-1];
  assign res_o.freq  = zero_q[STAGES-1] ? '0 : quo_q[STAGES-1];
  assign res_o.zero  = zero_q[STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/pfd_digits.sv]
`default_nettype none

module pfd_digits import pfd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         res_valid_i,
  output logic              res_ready_o,
  input  wire pfd_div_res_t res_i,
  pfd_out_if.source         out_if
);

  localparam int unsigned STAGES = 3;
  localparam logic [DEC_W-1:0] STEP_1000 = 14'd1000;
  localparam logic [DEC_W-1:0] STEP_100  = 14'd100;
  localparam logic [DEC_W-1:0] STEP_10   = 14'd10;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] en;

  logic [FREQ_W-1:0]  freq_a_q, freq_b_q, freq_c_q;
  logic               zero_a_q, zero_b_q;
  logic               sat_a_q, sat_b_q;
  logic [DIGIT_W-1:0] th_a_q, th_b_q;
  logic [DIGIT_W-1:0] hu_b_q;
  logic [9:0]         rem_a_q;
  logic [6:0]         rem_b_q;
  logic [DIGIT_W-1:0] th_c_q, hu_c_q, te_c_q, on_c_q;
  logic [STATUS_W-1:0] status_c_q;

  logic [DEC_W-1:0]   val_a, val_b, val_c;
  logic [DIGIT_W-1:0] th_a, hu_b, te_c, on_c;
  logic [9:0]         rem_a;
  logic [6:0]         rem_b;
  logic               sat_a;

  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en[k] = out_if.ready | ~(&valid_q[STAGES-1:k]);
  end

  assign res_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= res_valid_i;
      end
      if (en[1]) begin
        valid_q[1] <= valid_q[0];
      end
      if (en[2]) begin
        valid_q[2] <= valid_q[1];
      end
    end
  end

  // thousands
  always_comb begin
    val_a = res_i.freq[DEC_W-1:0];
    sat_a = (res_i.freq > DIGIT_LIMIT);
    th_a  = '0;
    for (int k = 1; k < 10; k++) begin
      if (val_a >= DEC_W'(k * 1000)) begin
        th_a = DIGIT_W'(k);
      end
    end
    rem_a = 10'(val_a - DEC_W'(th_a) * STEP_1000);
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && res_valid_i) begin
      freq_a_q <= res_i.freq;
      zero_a_q <= res_i.zero;
      sat_a_q  <= sat_a;
      th_a_q   <= th_a;
      rem_a_q  <= rem_a;
    end
  end

  // hundreds
  always_comb begin
    val_b = DEC_W'(rem_a_q);
    hu_b  = '0;
    for (int k = 1; k < 10; k++) begin
      if (val_b >= DEC_W'(k * 100)) begin
        hu_b = DIGIT_W'(k);
      end
    end
    rem_b = 7'(val_b - DEC_W'(hu_b) * STEP_100);
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && valid_q[0]) begin
      freq_b_q <= freq_a_q;
      zero_b_q <= zero_a_q;
      sat_b_q  <= sat_a_q;
      th_b_q   <= th_a_q;
      hu_b_q   <= hu_b;
      rem_b_q  <= rem_b;
    end
  end

  // tens and ones
  always_comb begin
    val_c = DEC_W'(rem_b_q);
    te_c  = '0;
    for (int k = 1; k < 10; k++) begin
      if (val_c >= DEC_W'(k * 10)) begin
        te_c = DIGIT_W'(k);
      end
    end
    on_c = DIGIT_W'(val_c - DEC_W'(te_c) * STEP_10);
  end

  always_ff @(posedge clk_i) begin
    if (en[2] && valid_q[1]) begin
      freq_c_q <= freq_b_q;
      if (zero_b_q) begin
        th_c_q     <= '0;
        hu_c_q     <= '0;
        te_c_q     <= '0;
        on_c_q     <= '0;
        status_c_q <= PFD_ZERO;
      end else if (sat_b_q) begin
        th_c_q     <= DIGIT_MAX;
        hu_c_q     <= DIGIT_MAX;
        te_c_q     <= DIGIT_MAX;
        on_c_q     <= DIGIT_MAX;
        status_c_q <= PFD_SAT;
      end else begin
        th_c_q     <= th_b_q;
        hu_c_q     <= hu_b_q;
        te_c_q     <= te_c;
        on_c_q     <= on_c;
        status_c_q <= PFD_OK;
      end
    end
  end

  assign out_if.valid           = valid_q[STAGES-1];
  assign out_if.frequency       = freq_c_q;
  assign out_if.digit_thousands = th_c_q;
  assign out_if.digit_hundreds  = hu_c_q;
  assign out_if.digit_tens      = te_c_q;
  assign out_if.digit_ones      = on_c_q;
  assign out_if.status          = status_c_q;

endmodule

`default_nettype wire

[hw/rtl/period_to_frequency_digits_unit.sv]
// period to frequency and display digits
//
// in_if carries one half-period timer count per item; out_if returns one
// result per item: rounded frequency = floor((rate + count) / (2 * count)),
// four decimal digits, and a status code (ok, saturated above 9999, zero count).
// cfg_we_i / cfg_wdata_i write the timer tick rate; write it only while idle.
//
// an accepted item passes through 28 register stages before its result is
// offered: one entry stage, 24 divider stages producing one quotient bit
// each (one compare and subtract per stage), and 3 digit stages.
// throughput is one item per cycle unless the receiver stalls; every stage
// holds one item.
// reset empties the pipeline and sets the tick rate to 1000000.
// when the receiver stalls, the result stays on out_if and items keep moving
// into empty stages behind it; in_if.ready drops only once every stage is full.
`default_nettype none

module period_to_frequency_digits_unit import pfd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [RATE_W-1:0] cfg_wdata_i,
  pfd_in_if.sink                 in_if,
  pfd_out_if.source              out_if
);

  logic [RATE_W-1:0] rate_q;
  logic              div_valid;
  logic              div_ready;
  pfd_div_res_t      div_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  pfd_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rate_i      (rate_q),
    .in_if       (in_if),
    .res_valid_o (div_valid),
    .res_ready_i (div_ready),
    .res_o       (div_res)
  );

  pfd_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (div_valid),
    .res_ready_o (div_ready),
    .res_i       (div_res),
    .out_if      (out_if)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input stalled while output side can move");

  a_digits_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == PFD_OK |->
      out_if.frequency == (FREQ_W'(out_if.digit_thousands) * 24'd1000
                         + FREQ_W'(out_if.digit_hundreds) * 24'd100
                         + FREQ_W'(out_if.digit_tens) * 24'd10
                         + FREQ_W'(out_if.digit_ones)))
    else $error("digits do not match frequency");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == PFD_SAT |->
      out_if.frequency > DIGIT_LIMIT && out_if.digit_thousands == DIGIT_MAX
      && out_if.digit_ones == DIGIT_MAX)
    else $error("saturated result inconsistent");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == PFD_ZERO |-> out_if.frequency == '0)
    else $error("zero count result has nonzero frequency");
`endif

endmodule

`default_nettype wire

[test/tb_period_to_frequency_digits_unit.sv]
`timescale 1ns / 1ps

module tb_period_to_frequency_digits_unit;
  import pfd_pkg::*;

  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned RAND_ITEMS = 1900 / NUM_PHASES;

  typedef struct packed {
    logic [FREQ_W-1:0]  frequency;
    logic [DIGIT_W-1:0] thousands;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
    pfd_status_e        status;
  } freq_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_LONG_STALL
  } rx_mode_e;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_wdata = '0;
  logic [RATE_W-1:0] tick_rate = RATE_RESET;

  pfd_in_if #(.COUNT_BITS(COUNT_W)) in_bus ();
  pfd_out_if out_bus ();

  period_to_frequency_digits_unit #(
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  always #5 clk = ~clk;

  logic [COUNT_W-1:0] pending_counts[$];
  freq_result_t       expected_results[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned zero_seen = 0;
  int unsigned rates_used = 1;

  function automatic freq_result_t convert_count(input logic [COUNT_W-1:0] cnt,
                                                 input logic [RATE_W-1:0] rate);
    freq_result_t     r;
    longint unsigned  f;
    r = '0;
    r.status = PFD_OK;
    if (cnt == '0) begin
      r.status = PFD_ZERO;
    end else begin
      f = rate;
      f = (f + cnt) / (64'd2 * cnt);
      r.frequency = f[FREQ_W-1:0];
      if (f > DIGIT_LIMIT) begin
        r.status    = PFD_SAT;
        r.thousands = DIGIT_MAX;
        r.hundreds  = DIGIT_MAX;
        r.tens      = DIGIT_MAX;
        r.ones      = DIGIT_MAX;
      end else begin
        r.thousands = DIGIT_W'(f / 1000);
        r.hundreds  = DIGIT_W'((f / 100) % 10);
        r.tens      = DIGIT_W'((f / 10) % 10);
        r.ones      = DIGIT_W'(f % 10);
      end
    end
    return r;
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  logic        in_accepted;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.count = '0;
    out_bus.ready = 1'b0;
  end

  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.count <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      in_accepted = in_bus.valid && in_bus.ready;
      if (in_accepted) begin
        expected_results.push_back(convert_count(in_bus.count, tick_rate));
      end
      if (!in_bus.valid || in_accepted) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_counts.size() != 0) begin
          in_bus.valid <= 1'b1;
          in_bus.count <= pending_counts.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between several modes
  rx_mode_e     rx_mode;
  int unsigned  mode_left;
  int unsigned  run_left;
  freq_result_t got, want;

  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rx_mode = RX_ALWAYS;
      mode_left = 100;
      run_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.frequency = out_bus.frequency;
        got.thousands = out_bus.digit_thousands;
        got.hundreds  = out_bus.digit_hundreds;
        got.tens      = out_bus.digit_tens;
        got.ones      = out_bus.digit_ones;
        got.status    = pfd_status_e'(out_bus.status);
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected item: freq %0d digits %0d%0d%0d%0d status %0d",
                     got.frequency, got.thousands, got.hundreds, got.tens, got.ones,
                     got.status);
          end
        end else begin
          want = expected_results.pop_front();
          if (want.status == PFD_SAT) sat_seen++;
          if (want.status == PFD_ZERO) zero_seen++;
          if (got.frequency !== want.frequency || got.thousands !== want.thousands ||
              got.hundreds !== want.hundreds || got.tens !== want.tens ||
              got.ones !== want.ones || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected freq %0d digits %0d%0d%0d%0d status %0d,",
                       want.frequency, want.thousands, want.hundreds, want.tens,
                       want.ones, want.status);
              $display("          got      freq %0d digits %0d%0d%0d%0d status %0d",
                       got.frequency, got.thousands, got.hundreds, got.tens, got.ones,
                       got.status);
            end
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left = mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: begin
          out_bus.ready <= 1'b1;
        end
        RX_COIN: begin
          out_bus.ready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          out_bus.ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          if (run_left == 0) begin
            out_bus.ready <= !out_bus.ready;
            run_left = out_bus.ready ? $urandom_range(20, 45) : $urandom_range(1, 8);
          end else begin
            run_left = run_left - 1;
          end
        end
      endcase
    end
  end

  function automatic logic [COUNT_W-1:0] pick_count(input logic [RATE_W-1:0] rate);
    int unsigned edge_cnt;
    edge_cnt = rate / 20000;
    if (edge_cnt > 65533) edge_cnt = 65533;
    case ($urandom_range(0, 15))
      0:       return '0;
      1, 2:    return COUNT_W'(edge_cnt + $urandom_range(0, 2));
      3, 4, 5: return COUNT_W'($urandom_range(1, 255));
      6:       return COUNT_W'($urandom_range(65280, 65535));
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_counts.size() != 0 || in_bus.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (32) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [RATE_W-1:0] rate);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= rate;
    tick_rate <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [RATE_W-1:0] rate_plan[NUM_PHASES];
  logic [COUNT_W-1:0] edge_counts[] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd49, 16'd50, 16'd51, 16'd52, 16'd100, 16'd999,
    16'd1000, 16'd255, 16'd256, 16'd20000, 16'h5555, 16'hAAAA, 16'h8000, 16'hFFFE,
    16'hFFFF
  };

  initial begin
    rate_plan = '{RATE_RESET, 24'd1, 24'hFFFFFF, 24'd0, 24'd19998, 24'd20000,
                  24'd0, 24'd0};
    rate_plan[6] = RATE_W'($urandom_range(1, 200000));
    rate_plan[7] = RATE_W'($urandom_range(1, 24'hFFFFFF));
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    foreach (edge_counts[k]) pending_counts.push_back(edge_counts[k]);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        write_tick_rate(rate_plan[p]);
        rates_used++;
        pending_counts.push_back(16'd1);
        pending_counts.push_back(16'hFFFF);
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        pending_counts.push_back(pick_count(rate_plan[p]));
      end
    end
    wait_drained();
    $display("checked %0d results over %0d tick rates (extremes 0, 1 and max included)",
             results_seen, rates_used);
    $display("%0d saturated and %0d zero-count items among them", sat_seen, zero_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d items still expected", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
